>>> rtl/bois_pkg.sv
// Shared types and constants for the buffer ownership interrupt service block.
package bois_pkg;

   localparam int DEF_BUFFER_COUNT = 4;

   localparam logic [1:0] ADDR_UNIT_MODE = 2'd0;

   localparam logic [1:0] MODE_INITIAL = 2'd0;
   localparam logic [1:0] MODE_OFFLINE = 2'd1;
   localparam logic [1:0] MODE_ONLINE  = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   typedef enum logic [1:0] {
      OP_EVENT   = 2'd0,
      OP_POST    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_MASK    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_SEND    = 2'd0,
      CMD_RECEIVE = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_FINAL   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      BUF_FREE     = 3'd0,
      BUF_WAIT_TX  = 3'd1,
      BUF_SENDING  = 3'd2,
      BUF_FILLING  = 3'd3,
      BUF_RECEIVED = 3'd4
   } buf_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TX,
      ST_RX,
      ST_EMIT_TX,
      ST_EMIT_RX,
      ST_EMIT_RC,
      ST_EMIT_FIN
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       tx_done;
      logic       rx_done;
      logic       recon_seen;
      logic [1:0] buffer_index;
      logic [2:0] mask_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  command_kind;
      logic [1:0]  command_buffer;
      logic [2:0]  enable_mask;
      logic [31:0] recon_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic     accept;
      logic     tx_step;
      logic     rx_step;
      logic     emit;
      kind_type emit_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic serve;
   } ctl_sts_type;

endpackage

>>> rtl/bois_datapath.sv
// Datapath: buffer states, enable mask, reconfiguration counter and result register.
module bois_datapath #(
   parameter int BUFFER_COUNT = bois_pkg::DEF_BUFFER_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bois_pkg::ctl_cmd_type cmd,
   output bois_pkg::ctl_sts_type sts,
   input  bois_pkg::req_type     req_item,
   input  logic [1:0]            unit_mode,
   output logic                  rsp_strobe,
   output bois_pkg::rsp_type     rsp_item
);
   import bois_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_COUNT);

   buf_state_type          status_ff [BUFFER_COUNT];
   buf_state_type          status_in [BUFFER_COUNT];
   logic [2:0]             mask_ff, mask_in;
   logic [31:0]            count_ff, count_in;
   logic [2:0]             ev_ff, ev_in;
   logic                   tx_hit_ff, tx_hit_in;
   logic                   rx_hit_ff, rx_hit_in;
   logic [IDX_W-1:0]       tx_pick_ff, tx_pick_in;
   logic [IDX_W-1:0]       rx_pick_ff, rx_pick_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic [2:0]             req_status;
   logic [IDX_W-1:0]       host_idx;
   logic                   idx_ok;
   logic                   tx_found, rx_found;
   logic [IDX_W-1:0]       tx_sel, rx_sel;
   logic                   emit_hit;

   assign req_status = {req_item.recon_seen, req_item.rx_done, req_item.tx_done};
   assign host_idx   = IDX_W'(req_item.buffer_index);
   assign idx_ok     = (32'(req_item.buffer_index) < 32'(BUFFER_COUNT));
   assign sts.serve  = (req_item.opcode == OP_EVENT) && (unit_mode == MODE_ONLINE) &&
                       ((req_status & mask_ff) != 3'd0);

   // lowest waiting buffer
   always_comb begin
      tx_found = 1'b0;
      tx_sel   = '0;
      for (int i = BUFFER_COUNT - 1; i >= 0; i--) begin
         if (status_ff[i] == BUF_WAIT_TX) begin
            tx_found = 1'b1;
            tx_sel   = IDX_W'(i);
         end
      end
   end

   // highest free buffer
   always_comb begin
      rx_found = 1'b0;
      rx_sel   = '0;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
         if (status_ff[i] == BUF_FREE) begin
            rx_found = 1'b1;
            rx_sel   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      status_in  = status_ff;
      mask_in    = mask_ff;
      count_in   = count_ff;
      ev_in      = ev_ff;
      tx_hit_in  = tx_hit_ff;
      rx_hit_in  = rx_hit_ff;
      tx_pick_in = tx_pick_ff;
      rx_pick_in = rx_pick_ff;
      if (cmd.accept) begin
         case (req_item.opcode)
            OP_POST: begin
               if (idx_ok && status_ff[host_idx] == BUF_FREE) begin
                  status_in[host_idx] = BUF_WAIT_TX;
                  mask_in[0]          = 1'b1;
               end
            end
            OP_RELEASE: begin
               if (idx_ok && status_ff[host_idx] == BUF_RECEIVED) begin
                  status_in[host_idx] = BUF_FREE;
                  mask_in[1]          = 1'b1;
               end
            end
            OP_MASK: begin
               mask_in = req_item.mask_value;
            end
            default: begin
               ev_in     = req_status;
               tx_hit_in = 1'b0;
               rx_hit_in = 1'b0;
            end
         endcase
      end
      if (cmd.tx_step && ev_ff[0]) begin
         for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (status_ff[i] == BUF_SENDING) begin
               status_in[i] = BUF_FREE;
            end
         end
         if (tx_found) begin
            status_in[tx_sel] = BUF_SENDING;
            tx_hit_in         = 1'b1;
            tx_pick_in        = tx_sel;
         end else begin
            mask_in[0] = 1'b0;
         end
      end
      if (cmd.rx_step) begin
         if (ev_ff[1]) begin
            for (int i = 0; i < BUFFER_COUNT; i++) begin
               if (status_ff[i] == BUF_FILLING) begin
                  status_in[i] = BUF_RECEIVED;
               end
            end
            if (rx_found) begin
               status_in[rx_sel] = BUF_FILLING;
               rx_hit_in         = 1'b1;
               rx_pick_in        = rx_sel;
            end else begin
               mask_in[1] = 1'b0;
            end
         end
         if (ev_ff[2]) begin
            count_in = count_ff + 32'd1;
         end
      end
   end

   always_comb begin
      case (cmd.emit_kind)
         CMD_SEND:    emit_hit = tx_hit_ff;
         CMD_RECEIVE: emit_hit = rx_hit_ff;
         CMD_CLEAR:   emit_hit = ev_ff[2];
         default:     emit_hit = 1'b1;
      endcase
      rsp_strobe_in              = cmd.emit && emit_hit;
      rsp_in.command_kind        = cmd.emit_kind;
      case (cmd.emit_kind)
         CMD_SEND:    rsp_in.command_buffer = 2'(tx_pick_ff);
         CMD_RECEIVE: rsp_in.command_buffer = 2'(rx_pick_ff);
         default:     rsp_in.command_buffer = 2'd0;
      endcase
      rsp_in.enable_mask = mask_ff;
      rsp_in.recon_total = count_ff;
      rsp_in.last        = (cmd.emit_kind == CMD_FINAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUFFER_COUNT; i++) begin
            status_ff[i] <= BUF_FREE;
         end
         mask_ff       <= 3'd0;
         count_ff      <= 32'd0;
         ev_ff         <= 3'd0;
         tx_hit_ff     <= 1'b0;
         rx_hit_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         status_ff     <= status_in;
         mask_ff       <= mask_in;
         count_ff      <= count_in;
         ev_ff         <= ev_in;
         tx_hit_ff     <= tx_hit_in;
         rx_hit_ff     <= rx_hit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_pick_ff <= tx_pick_in;
      rx_pick_ff <= rx_pick_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

>>> rtl/bois_ctrl.sv
// Controller: sequences the transmit, receive and result steps of a served event.
module bois_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bois_pkg::ctl_sts_type sts,
   output bois_pkg::ctl_cmd_type cmd
);
   import bois_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (start && sts.serve) state_in = ST_TX;
         ST_TX:       state_in = ST_RX;
         ST_RX:       state_in = ST_EMIT_TX;
         ST_EMIT_TX:  state_in = ST_EMIT_RX;
         ST_EMIT_RX:  state_in = ST_EMIT_RC;
         ST_EMIT_RC:  state_in = ST_EMIT_FIN;
         ST_EMIT_FIN: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.accept    = 1'b0;
      cmd.tx_step   = 1'b0;
      cmd.rx_step   = 1'b0;
      cmd.emit      = 1'b0;
      cmd.emit_kind = CMD_FINAL;
      busy          = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         ST_TX: cmd.tx_step = 1'b1;
         ST_RX: cmd.rx_step = 1'b1;
         ST_EMIT_TX: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = CMD_SEND;
         end
         ST_EMIT_RX: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = CMD_RECEIVE;
         end
         ST_EMIT_RC: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = CMD_CLEAR;
         end
         ST_EMIT_FIN: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = CMD_FINAL;
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/buffer_ownership_interrupt_service_top.sv
// Top level: mode register, controller and datapath of the buffer ownership interrupt service.
//
// Input channel: an item on req_item is transferred at a rising edge with start high and
// busy low. Post, release and set-mask items take effect at that edge and give no result;
// busy stays low, so the next item can follow in the next cycle.
// An interrupt event that is served (unit online and an enabled status bit present) raises
// busy for the transmit retirement step, the receive retirement and reconfiguration count
// step, then four result slots. An event that is not served gives no result.
// Results appear on rsp_item for one cycle each, marked by rsp_strobe, registered from the
// result slots that follow the transmit and receive steps: optional send, receive and clear
// commands, then a final item with last set. Every result of an event carries the mask and
// count as they stand after the event; busy falls after the final slot. The receiver cannot
// stall; results are never held. Configuration: unit_mode at address 0 on the APB-style port,
// written only while idle by the user; the block itself does not enforce this. Reset
// (synchronous, active high) frees all buffers and clears mask, counter and mode.
module buffer_ownership_interrupt_service_top #(
   parameter int BUFFER_COUNT = bois_pkg::DEF_BUFFER_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bois_pkg::req_type req_item,
   output logic              rsp_strobe,
   output bois_pkg::rsp_type rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import bois_pkg::*;

   logic [1:0]  mode_ff, mode_in;
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign pready = 1'b1;
   assign prdata = {30'd0, mode_ff};

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && pready && paddr == ADDR_UNIT_MODE) begin
         mode_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_INITIAL;
      end else begin
         mode_ff <= mode_in;
      end
   end

   bois_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   bois_datapath #(
      .BUFFER_COUNT (BUFFER_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_item   (req_item),
      .unit_mode  (mode_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
